FILE: src/gref_pkg.sv
// Shared types and constants for the GRE-over-IPv4 encapsulating fragmenter.
// Used by gref_front, gref_fifo, gref_back, the top level and the checker.
package gref_pkg;

    localparam int CmdQueueDepth = 4;
    localparam int CmdPtrWidth   = $clog2(CmdQueueDepth);

    localparam logic [15:0] MTU_RESET      = 16'd1500;
    localparam logic [7:0]  TTL_RESET      = 8'd25;
    localparam logic [15:0] HDR_LEN        = 16'd20;
    localparam logic [15:0] GRE_LEN        = 16'd4;
    localparam logic [15:0] MAX_INNER      = 16'd65511;
    localparam logic [15:0] MIN_MTU_SPLIT  = 16'd28;
    localparam logic [15:0] MIN_CHUNK      = 16'd8;
    localparam logic [7:0]  IP_VER_IHL     = 8'h45;
    localparam logic [7:0]  IP_PROTO_GRE   = 8'd47;
    localparam logic [7:0]  ETH_V6_HI      = 8'h86;
    localparam logic [7:0]  ETH_V6_LO      = 8'hDD;
    localparam logic [7:0]  ETH_V4_HI      = 8'h08;
    localparam logic [7:0]  ETH_V4_LO      = 8'h00;
    localparam logic [3:0]  IP_V6_NIBBLE   = 4'h6;
    localparam logic [15:0] CSUM_INIT      = 16'hFFFF;

    typedef enum logic [1:0] {
        REG_LOCAL_ADDR  = 2'd0,
        REG_REMOTE_ADDR = 2'd1,
        REG_TTL         = 2'd2,
        REG_LINK_MTU    = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        B_RUN,
        B_HDR,
        B_DATA
    } back_state_t;

    // One GRE payload byte handed from the front to the back.
    typedef struct packed {
        logic [7:0]  data;
        logic        start;
        logic [15:0] total;
        logic [15:0] ident;
        logic        last;
    } cmd_t;

    typedef struct packed {
        logic [31:0] local_address;
        logic [31:0] remote_address;
        logic [7:0]  hop_ttl;
        logic [15:0] chunk_limit;
    } cfg_t;

endpackage

FILE: src/gref_fifo.sv
// Small command queue between the front and the back of the fragmenter.
// Depends on gref_pkg (cmd_t, queue depth).
module gref_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  gref_pkg::cmd_t wr_data,
    output logic           q_full,
    input  logic           rd_en,
    output gref_pkg::cmd_t rd_data,
    output logic           q_empty
);

    gref_pkg::cmd_t                      mem [gref_pkg::CmdQueueDepth];
    logic [gref_pkg::CmdPtrWidth-1:0]    wr_ptr_reg;
    logic [gref_pkg::CmdPtrWidth-1:0]    wr_ptr_next;
    logic [gref_pkg::CmdPtrWidth-1:0]    rd_ptr_reg;
    logic [gref_pkg::CmdPtrWidth-1:0]    rd_ptr_next;
    logic [gref_pkg::CmdPtrWidth:0]      count_reg;
    logic [gref_pkg::CmdPtrWidth:0]      count_next;
    logic                                do_wr;
    logic                                do_rd;

    assign q_full  = (count_reg == (gref_pkg::CmdPtrWidth+1)'(gref_pkg::CmdQueueDepth));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/gref_front.sv
// Front end: accepts inner bytes, tracks the open packet, drops stray bytes
// and expands a first byte into GRE header bytes. Depends on gref_pkg.
module gref_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic [7:0]     data_byte,
    input  logic           first_of_packet,
    input  logic [15:0]    packet_length,
    input  logic [15:0]    packet_ident,
    output logic           cmd_push,
    output gref_pkg::cmd_t cmd_data,
    input  logic           cmd_full
);

    logic        pend_valid_reg;
    logic        pend_valid_next;
    logic [7:0]  pbyte_reg;
    logic        pfirst_reg;
    logic [15:0] plen_reg;
    logic [15:0] pident_reg;
    logic [2:0]  step_reg;
    logic [2:0]  step_next;
    logic [15:0] rem_reg;
    logic [15:0] rem_next;
    logic        accept;
    logic        drop;
    logic        last_step;
    logic        finishing;
    logic        is_v6;
    logic [15:0] clamped_len;

    assign is_v6     = (pbyte_reg[7:4] == gref_pkg::IP_V6_NIBBLE);
    assign drop      = pend_valid_reg && !pfirst_reg && (rem_reg == '0);
    assign last_step = pfirst_reg ? (step_reg == 3'd4) : 1'b1;
    assign cmd_push  = pend_valid_reg && !drop && !cmd_full;
    assign finishing = drop || (cmd_push && last_step);
    assign full      = pend_valid_reg && !finishing;
    assign accept    = push && !full;

    always_comb
    begin
        if (plen_reg == '0)
        begin
            clamped_len = 16'd1;
        end
        else if (plen_reg > gref_pkg::MAX_INNER)
        begin
            clamped_len = gref_pkg::MAX_INNER;
        end
        else
        begin
            clamped_len = plen_reg;
        end
    end

    always_comb
    begin
        cmd_data.start = pfirst_reg && (step_reg == 3'd0);
        cmd_data.total = clamped_len + gref_pkg::GRE_LEN;
        cmd_data.ident = pident_reg;
        cmd_data.last  = last_step;
        cmd_data.data  = pbyte_reg;
        if (pfirst_reg)
        begin
            case (step_reg) inside
                3'd0, 3'd1: cmd_data.data = 8'h00;
                3'd2:       cmd_data.data = is_v6 ? gref_pkg::ETH_V6_HI : gref_pkg::ETH_V4_HI;
                3'd3:       cmd_data.data = is_v6 ? gref_pkg::ETH_V6_LO : gref_pkg::ETH_V4_LO;
                default:    cmd_data.data = pbyte_reg;
            endcase
        end
    end

    always_comb
    begin
        rem_next        = rem_reg;
        step_next       = step_reg;
        pend_valid_next = accept || (pend_valid_reg && !finishing);
        if (cmd_push)
        begin
            rem_next  = (cmd_data.start ? cmd_data.total : rem_reg) - 16'd1;
            step_next = step_reg + 3'd1;
        end
        if (accept)
        begin
            step_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pbyte_reg  <= data_byte;
            pfirst_reg <= first_of_packet;
            plen_reg   <= packet_length;
            pident_reg <= packet_ident;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            step_reg       <= '0;
            rem_reg        <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            step_reg       <= step_next;
            rem_reg        <= rem_next;
        end
    end

endmodule

FILE: src/gref_back.sv
// Back end: splits GRE payload bytes into IPv4 fragments, emits each 20-byte
// header with its checksum, and holds the result register. Depends on gref_pkg.
module gref_back (
    input  logic           clk,
    input  logic           rst_n,
    input  gref_pkg::cfg_t cfg,
    input  gref_pkg::cmd_t cmd_data,
    input  logic           cmd_empty,
    output logic           cmd_pop,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     out_byte,
    output logic           fragment_end,
    output logic           packet_end,
    output logic           run_end
);

    gref_pkg::back_state_t state_reg;
    gref_pkg::back_state_t state_next;

    logic [15:0] total_reg,  total_next;
    logic [15:0] off_reg,    off_next;
    logic [15:0] left_reg,   left_next;
    logic [15:0] ident_reg,  ident_next;
    logic [15:0] chunk_reg,  chunk_next;
    logic        mf_reg,     mf_next;
    logic [4:0]  cnt_reg,    cnt_next;
    logic [15:0] acc_reg,    acc_next;
    logic [7:0]  byte_reg,   byte_next;
    logic        last_reg,   last_next;

    logic        ovalid_reg, ovalid_next;
    logic [7:0]  obyte_reg,  obyte_next;
    logic        ofend_reg,  ofend_next;
    logic        opend_reg,  opend_next;
    logic        orun_reg,   orun_next;

    logic        advance;
    logic [15:0] eff_total;
    logic [15:0] eff_off;
    logic [15:0] eff_left;
    logic [15:0] remain;
    logic        need_hdr;
    logic        over_limit;
    logic [15:0] tot_len;
    logic [15:0] frag_word;
    logic [15:0] csum;
    logic [15:0] hdr_word;
    logic [7:0]  hdr_byte;
    logic [16:0] acc_sum;

    assign advance    = !ovalid_reg || pop;
    assign eff_total  = cmd_data.start ? cmd_data.total : total_reg;
    assign eff_off    = cmd_data.start ? 16'd0 : off_reg;
    assign eff_left   = cmd_data.start ? 16'd0 : left_reg;
    assign remain     = eff_total - eff_off;
    assign need_hdr   = (eff_left == '0);
    assign over_limit = (remain > cfg.chunk_limit);
    assign tot_len    = gref_pkg::HDR_LEN + chunk_reg;
    assign frag_word  = {2'b00, mf_reg, off_reg[15:3]};
    assign csum       = ~acc_reg;

    always_comb
    begin
        case (cnt_reg[3:0])
            4'd0:    hdr_word = {gref_pkg::IP_VER_IHL, 8'h00};
            4'd1:    hdr_word = tot_len;
            4'd2:    hdr_word = ident_reg;
            4'd3:    hdr_word = frag_word;
            4'd4:    hdr_word = {cfg.hop_ttl, gref_pkg::IP_PROTO_GRE};
            4'd6:    hdr_word = cfg.local_address[31:16];
            4'd7:    hdr_word = cfg.local_address[15:0];
            4'd8:    hdr_word = cfg.remote_address[31:16];
            4'd9:    hdr_word = cfg.remote_address[15:0];
            default: hdr_word = 16'h0000;
        endcase
        acc_sum = {1'b0, acc_reg} + {1'b0, hdr_word};
    end

    always_comb
    begin
        case (cnt_reg)
            5'd0:    hdr_byte = gref_pkg::IP_VER_IHL;
            5'd2:    hdr_byte = tot_len[15:8];
            5'd3:    hdr_byte = tot_len[7:0];
            5'd4:    hdr_byte = ident_reg[15:8];
            5'd5:    hdr_byte = ident_reg[7:0];
            5'd6:    hdr_byte = frag_word[15:8];
            5'd7:    hdr_byte = frag_word[7:0];
            5'd8:    hdr_byte = cfg.hop_ttl;
            5'd9:    hdr_byte = gref_pkg::IP_PROTO_GRE;
            5'd10:   hdr_byte = csum[15:8];
            5'd11:   hdr_byte = csum[7:0];
            5'd12:   hdr_byte = cfg.local_address[31:24];
            5'd13:   hdr_byte = cfg.local_address[23:16];
            5'd14:   hdr_byte = cfg.local_address[15:8];
            5'd15:   hdr_byte = cfg.local_address[7:0];
            5'd16:   hdr_byte = cfg.remote_address[31:24];
            5'd17:   hdr_byte = cfg.remote_address[23:16];
            5'd18:   hdr_byte = cfg.remote_address[15:8];
            5'd19:   hdr_byte = cfg.remote_address[7:0];
            default: hdr_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gref_pkg::B_RUN:
            begin
                if (advance && !cmd_empty && need_hdr)
                begin
                    state_next = gref_pkg::B_HDR;
                end
            end
            gref_pkg::B_HDR:
            begin
                if (advance && (cnt_reg == 5'd19))
                begin
                    state_next = gref_pkg::B_DATA;
                end
            end
            gref_pkg::B_DATA:
            begin
                if (advance)
                begin
                    state_next = gref_pkg::B_RUN;
                end
            end
            default: state_next = gref_pkg::B_RUN;
        endcase
    end

    always_comb
    begin
        total_next  = total_reg;
        off_next    = off_reg;
        left_next   = left_reg;
        ident_next  = ident_reg;
        chunk_next  = chunk_reg;
        mf_next     = mf_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        cmd_pop     = 1'b0;
        ovalid_next = ovalid_reg && !pop;
        obyte_next  = obyte_reg;
        ofend_next  = ofend_reg;
        opend_next  = opend_reg;
        orun_next   = orun_reg;
        if (advance)
        begin
            unique case (state_reg)
                gref_pkg::B_RUN:
                begin
                    if (!cmd_empty)
                    begin
                        cmd_pop    = 1'b1;
                        total_next = eff_total;
                        if (cmd_data.start)
                        begin
                            ident_next = cmd_data.ident;
                        end
                        if (need_hdr)
                        begin
                            chunk_next = over_limit ? cfg.chunk_limit : remain;
                            mf_next    = over_limit;
                            left_next  = over_limit ? cfg.chunk_limit : remain;
                            off_next   = eff_off;
                            cnt_next   = '0;
                            acc_next   = gref_pkg::CSUM_INIT;
                            byte_next  = cmd_data.data;
                            last_next  = cmd_data.last;
                        end
                        else
                        begin
                            ovalid_next = 1'b1;
                            obyte_next  = cmd_data.data;
                            ofend_next  = (eff_left == 16'd1);
                            opend_next  = (eff_off + 16'd1 == eff_total);
                            orun_next   = cmd_data.last;
                            left_next   = eff_left - 16'd1;
                            off_next    = eff_off + 16'd1;
                        end
                    end
                end
                gref_pkg::B_HDR:
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = hdr_byte;
                    ofend_next  = 1'b0;
                    opend_next  = 1'b0;
                    orun_next   = 1'b0;
                    cnt_next    = cnt_reg + 5'd1;
                    if (cnt_reg < 5'd10)
                    begin
                        acc_next = acc_sum[16] ? acc_sum[15:0] + 16'd1 : acc_sum[15:0];
                    end
                end
                gref_pkg::B_DATA:
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = byte_reg;
                    ofend_next  = (left_reg == 16'd1);
                    opend_next  = (off_reg + 16'd1 == total_reg);
                    orun_next   = last_reg;
                    left_next   = left_reg - 16'd1;
                    off_next    = off_reg + 16'd1;
                end
                default:
                begin
                    ovalid_next = 1'b0;
                end
            endcase
        end
    end

    assign empty        = !ovalid_reg;
    assign out_byte     = obyte_reg;
    assign fragment_end = ofend_reg;
    assign packet_end   = opend_reg;
    assign run_end      = orun_reg;

    always_ff @(posedge clk)
    begin
        chunk_reg <= chunk_next;
        mf_reg    <= mf_next;
        acc_reg   <= acc_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        obyte_reg <= obyte_next;
        ofend_reg <= ofend_next;
        opend_reg <= opend_next;
        orun_reg  <= orun_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= gref_pkg::B_RUN;
            total_reg  <= '0;
            off_reg    <= '0;
            left_reg   <= '0;
            ident_reg  <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            off_reg    <= off_next;
            left_reg   <= left_next;
            ident_reg  <= ident_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

FILE: src/gre_ipv4_encap_fragmenter_unit.sv
// Top level of the GRE-over-IPv4 encapsulating fragmenter: configuration
// registers, front end, command queue and back end. Depends on gref_pkg.
//
// Usage:
//   Input queue: drive push with data_byte; first_of_packet marks a new inner
//   packet and qualifies packet_length and packet_ident. A transaction takes
//   place when push is high and full is low.
//   Result queue: while empty is low, out_byte and the end flags show the
//   oldest result; it is taken when pop is high.
//   Config: cfg_write with cfg_index/cfg_data, only while the block is idle.
// Path: pending register in the front end, command queue, result register in
//   the back end; a byte that opens a fragment waits for a load and the header.
// Throughput: one transaction per cycle on input while the command queue has
//   room; the back end emits one byte per cycle while results are taken, and
//   each fragment adds its 20 header bytes and a load step. A first byte expands
//   to five payload bytes; full stays high while the front end pushes them.
// Reset: clears the queues and packet state; addresses 0, TTL 25, MTU 1500.
// Stall: with pop low the result holds, the queue fills and full rises.
module gre_ipv4_encap_fragmenter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        first_of_packet,
    input  logic [15:0] packet_length,
    input  logic [15:0] packet_ident,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        fragment_end,
    output logic        packet_end,
    output logic        run_end,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0]    local_reg;
    logic [31:0]    remote_reg;
    logic [7:0]     ttl_reg;
    logic [15:0]    mtu_reg;
    logic [15:0]    limit_reg;
    logic [15:0]    limit_next;
    logic [15:0]    mtu_less_hdr;
    gref_pkg::cfg_t cfg;

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    gref_pkg::cmd_t q_wr_data;
    gref_pkg::cmd_t q_rd_data;

    assign mtu_less_hdr = mtu_reg - gref_pkg::HDR_LEN;
    assign limit_next   = (mtu_reg < gref_pkg::MIN_MTU_SPLIT) ? gref_pkg::MIN_CHUNK
                                                               : {mtu_less_hdr[15:3], 3'b000};

    assign cfg.local_address  = local_reg;
    assign cfg.remote_address = remote_reg;
    assign cfg.hop_ttl        = ttl_reg;
    assign cfg.chunk_limit    = limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_reg  <= '0;
            remote_reg <= '0;
            ttl_reg    <= gref_pkg::TTL_RESET;
            mtu_reg    <= gref_pkg::MTU_RESET;
            limit_reg  <= {gref_pkg::MTU_RESET[15:3] - gref_pkg::HDR_LEN[15:3], 3'b000};
        end
        else
        begin
            limit_reg <= limit_next;
            if (cfg_write)
            begin
                unique case (gref_pkg::reg_index_t'(cfg_index))
                    gref_pkg::REG_LOCAL_ADDR:  local_reg  <= cfg_data;
                    gref_pkg::REG_REMOTE_ADDR: remote_reg <= cfg_data;
                    gref_pkg::REG_TTL:         ttl_reg    <= cfg_data[7:0];
                    gref_pkg::REG_LINK_MTU:    mtu_reg    <= cfg_data[15:0];
                    default:                   local_reg  <= local_reg;
                endcase
            end
        end
    end

    gref_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .data_byte       (data_byte),
        .first_of_packet (first_of_packet),
        .packet_length   (packet_length),
        .packet_ident    (packet_ident),
        .cmd_push        (q_push),
        .cmd_data        (q_wr_data),
        .cmd_full        (q_full)
    );

    gref_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .q_empty (q_empty)
    );

    gref_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd_data     (q_rd_data),
        .cmd_empty    (q_empty),
        .cmd_pop      (q_pop),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .fragment_end (fragment_end),
        .packet_end   (packet_end),
        .run_end      (run_end)
    );

endmodule

FILE: src/gref_checker.sv
// Port-level checks for gre_ipv4_encap_fragmenter_unit, bound to the top level.
// Sees only the top-level ports; no package dependency.
module gref_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       fragment_end,
    input logic       packet_end,
    input logic       run_end
);

    // last byte of a packet always closes its fragment
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && packet_end) |-> fragment_end)
        else $error("packet_end without fragment_end");

    // the final packet byte is the inner byte itself, so it ends its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && packet_end) |-> run_end)
        else $error("packet_end without run_end");

    // a waiting result holds until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(fragment_end)
                              && $stable(packet_end) && $stable(run_end)))
        else $error("result changed while stalled");

endmodule

bind gre_ipv4_encap_fragmenter_unit gref_checker u_gref_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .fragment_end (fragment_end),
    .packet_end   (packet_end),
    .run_end      (run_end)
);

FILE: tb/sv/gref_frag_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the GRE-over-IPv4 fragmenter: mirrors register writes, predicts
// the outer byte stream of every input transaction and checks each result.
// Depends on gref_pkg.
module gref_frag_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  data_byte,
    input  logic        first_of_packet,
    input  logic [15:0] packet_length,
    input  logic [15:0] packet_ident,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  out_byte,
    input  logic        fragment_end,
    input  logic        packet_end,
    input  logic        run_end,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          waiting
);
    import gref_pkg::*;

    localparam logic [15:0] FRAG_OFS_MASK = 16'h1FFF;
    localparam logic [15:0] MORE_FRAGS    = 16'h2000;

    typedef struct packed {
        logic [7:0] data;
        logic       frag_last;
        logic       pkt_last;
        logic       step_last;
    } frag_byte_t;

    frag_byte_t  outer_bytes_q[$];
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  ttl;
    logic [15:0] mtu;
    logic        pkt_open;
    logic [15:0] pay_total;
    logic [15:0] pay_sent;
    logic [15:0] frag_left;
    logic [15:0] cur_ident;
    int          step_results;
    int          errors;

    assign fail_count = errors;

    function automatic int chunk_cap(logic [15:0] m);
        if (m < MIN_MTU_SPLIT)
            return int'(MIN_CHUNK);
        return ((int'(m) - int'(HDR_LEN)) / 8) * 8;
    endfunction

    task automatic add_byte(logic [7:0] b, logic fe, logic pe);
        outer_bytes_q.push_back('{b, fe, pe, 1'b0});
        step_results++;
    endtask

    // 20-byte outer IPv4 header for the fragment starting at pay_sent
    task automatic open_fragment();
        logic [7:0]  h [20];
        int          chunk;
        int          i;
        logic [15:0] tot;
        logic [15:0] frag;
        logic [31:0] acc;
        chunk = int'(pay_total) - int'(pay_sent);
        if (chunk > chunk_cap(mtu))
            chunk = chunk_cap(mtu);
        tot = HDR_LEN + 16'(chunk);
        frag = (pay_sent / 16'd8) & FRAG_OFS_MASK;
        if (int'(pay_sent) + chunk < int'(pay_total))
            frag = frag | MORE_FRAGS;
        h[0] = IP_VER_IHL;
        h[1] = 8'h00;
        h[2] = tot[15:8];
        h[3] = tot[7:0];
        h[4] = cur_ident[15:8];
        h[5] = cur_ident[7:0];
        h[6] = frag[15:8];
        h[7] = frag[7:0];
        h[8] = ttl;
        h[9] = IP_PROTO_GRE;
        h[10] = 8'h00;
        h[11] = 8'h00;
        for (i = 0; i < 4; i++)
        begin
            h[12 + i] = src_addr[31 - 8 * i -: 8];
            h[16 + i] = dst_addr[31 - 8 * i -: 8];
        end
        acc = 32'(CSUM_INIT);
        for (i = 0; i < 20; i += 2)
        begin
            acc = acc + {16'h0000, h[i], h[i + 1]};
            if (acc > 32'h0000_FFFF)
                acc = acc - 32'h0000_FFFF;
        end
        acc = ~acc;
        h[10] = acc[15:8];
        h[11] = acc[7:0];
        for (i = 0; i < 20; i++)
            add_byte(h[i], 1'b0, 1'b0);
        frag_left = 16'(chunk);
    endtask

    task automatic send_payload(logic [7:0] b);
        logic fe;
        logic pe;
        if (!pkt_open)
            return;
        if (frag_left == 16'd0)
            open_fragment();
        fe = (frag_left == 16'd1);
        pe = (pay_sent + 16'd1 == pay_total);
        add_byte(b, fe, pe);
        frag_left--;
        pay_sent++;
        if (pay_sent >= pay_total)
            pkt_open = 1'b0;
    endtask

    task automatic predict_encap(logic [7:0] d, logic first, logic [15:0] len,
                                 logic [15:0] ident);
        logic [15:0] l;
        frag_byte_t  tail;
        step_results = 0;
        if (first)
        begin
            l = len;
            if (l < 16'd1)
                l = 16'd1;
            if (l > MAX_INNER)
                l = MAX_INNER;
            cur_ident = ident;
            pay_total = l + GRE_LEN;
            pay_sent = 16'd0;
            frag_left = 16'd0;
            pkt_open = 1'b1;
            send_payload(8'h00);
            send_payload(8'h00);
            if (d[7:4] == IP_V6_NIBBLE)
            begin
                send_payload(ETH_V6_HI);
                send_payload(ETH_V6_LO);
            end
            else
            begin
                send_payload(ETH_V4_HI);
                send_payload(ETH_V4_LO);
            end
        end
        send_payload(d);
        if (step_results > 0)
        begin
            tail = outer_bytes_q.pop_back();
            tail.step_last = 1'b1;
            outer_bytes_q.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frag_byte_t got;
        frag_byte_t want;
        if (!rst_n)
        begin
            outer_bytes_q.delete();
            src_addr = 32'd0;
            dst_addr = 32'd0;
            ttl = TTL_RESET;
            mtu = MTU_RESET;
            pkt_open = 1'b0;
            pay_total = 16'd0;
            pay_sent = 16'd0;
            frag_left = 16'd0;
            cur_ident = 16'd0;
            errors = 0;
            waiting <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (reg_index_t'(cfg_index))
                    REG_LOCAL_ADDR:  src_addr = cfg_data;
                    REG_REMOTE_ADDR: dst_addr = cfg_data;
                    REG_TTL:         ttl = cfg_data[7:0];
                    REG_LINK_MTU:    mtu = cfg_data[15:0];
                    default:         ;
                endcase
            end
            if (pop && !empty)
            begin
                got = '{out_byte, fragment_end, packet_end, run_end};
                if (outer_bytes_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: byte %02h fe %0b pe %0b re %0b",
                                 got.data, got.frag_last, got.pkt_last, got.step_last);
                end
                else
                begin
                    want = outer_bytes_q.pop_front();
                    if (got.data !== want.data || got.frag_last !== want.frag_last ||
                        got.pkt_last !== want.pkt_last || got.step_last !== want.step_last)
                    begin
                        errors++;
                        // byte/fragment_end/packet_end/run_end
                        if (errors <= 10)
                            $display("mismatch: exp %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                                     want.data, want.frag_last, want.pkt_last, want.step_last,
                                     got.data, got.frag_last, got.pkt_last, got.step_last);
                    end
                end
            end
            if (push && !full)
                predict_encap(data_byte, first_of_packet, packet_length, packet_ident);
            waiting <= outer_bytes_q.size();
        end
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the fragmenter testbench: clock, reset, register writes, byte stimulus
// and result pacing. Depends on gref_pkg, gref_frag_checker and the block.
module testbench;
    import gref_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 30;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = 8'h00;
    logic        first_of_packet = 1'b0;
    logic [15:0] packet_length = 16'h0000;
    logic [15:0] packet_ident = 16'h0000;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  out_byte;
    logic        fragment_end;
    logic        packet_end;
    logic        run_end;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'd0;
    int          fail_count;
    int          waiting;
    int          send_idle = 25;
    int          recv_idle = 76;
    bit          hold_req = 1'b0;

    always #4 clk = ~clk;

    gre_ipv4_encap_fragmenter_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .data_byte(data_byte),
        .first_of_packet(first_of_packet),
        .packet_length(packet_length),
        .packet_ident(packet_ident),
        .empty(empty),
        .pop(pop),
        .out_byte(out_byte),
        .fragment_end(fragment_end),
        .packet_end(packet_end),
        .run_end(run_end),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    gref_frag_checker u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .data_byte(data_byte),
        .first_of_packet(first_of_packet),
        .packet_length(packet_length),
        .packet_ident(packet_ident),
        .empty(empty),
        .pop(pop),
        .out_byte(out_byte),
        .fragment_end(fragment_end),
        .packet_end(packet_end),
        .run_end(run_end),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .waiting(waiting)
    );

    // one input transaction, entered and left at a rising edge
    task automatic send_byte(logic [7:0] d, logic first, logic [15:0] len,
                             logic [15:0] ident);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= d;
        first_of_packet <= first;
        packet_length <= len;
        packet_ident <= ident;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_config();
        int pick;
        write_reg(REG_LOCAL_ADDR, $urandom);
        write_reg(REG_REMOTE_ADDR, $urandom);
        write_reg(REG_TTL, $urandom_range(255));
        pick = $urandom_range(3);
        case (pick)
            0:       write_reg(REG_LINK_MTU, 32'd68);
            1:       write_reg(REG_LINK_MTU, $urandom_range(100, 28));
            2:       write_reg(REG_LINK_MTU, $urandom_range(27, 0));
            default: write_reg(REG_LINK_MTU, $urandom_range(65535, 101));
        endcase
    endtask

    // well-formed packets, truncated packets and stray bytes
    task automatic run_random(int quota);
        int          done;
        int          kind;
        int          len;
        int          cut;
        int          i;
        logic [7:0]  d;
        done = 0;
        while (done < quota)
        begin
            kind = $urandom_range(99);
            if (kind < 6)
            begin
                send_byte(8'($urandom), 1'b0, 16'($urandom), 16'($urandom));
                done++;
            end
            else
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(300, 61)
                                                : $urandom_range(60, 1);
                cut = (kind < 16 && len > 1) ? $urandom_range(len - 1, 1) : len;
                if (cut > quota - done)
                    cut = quota - done;
                d = 8'($urandom);
                if ($urandom_range(1) == 1)
                    d[7:4] = IP_V6_NIBBLE;
                send_byte(d, 1'b1, 16'(len), 16'($urandom));
                for (i = 1; i < cut; i++)
                    send_byte(8'($urandom), 1'b0, 16'($urandom), 16'($urandom));
                done += cut;
            end
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int i;
        int phase;
        int blk;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values; stray byte, zero and oversized lengths, abandon
        send_byte(8'hFF, 1'b0, 16'h0000, 16'h0000);
        send_byte(8'h60, 1'b1, 16'h0000, 16'hFFFF);
        send_byte(8'h00, 1'b0, 16'hFFFF, 16'hFFFF);
        send_byte(8'h45, 1'b1, 16'd3, 16'h0000);
        send_byte(8'h00, 1'b0, 16'h0000, 16'h0000);
        send_byte(8'hFF, 1'b0, 16'h0000, 16'h0000);
        send_byte(8'h6F, 1'b1, 16'hFFFF, 16'hA5A5);
        send_byte(8'h12, 1'b0, 16'h0000, 16'h0000);
        send_byte(8'h7F, 1'b1, MAX_INNER, 16'h5A5A);
        send_byte(8'h34, 1'b0, 16'h0000, 16'h0000);
        drain_results();

        // tiny MTU, then a huge one in the middle of the packet
        write_reg(REG_LOCAL_ADDR, 32'hFFFF_FFFF);
        write_reg(REG_REMOTE_ADDR, 32'h0000_0000);
        write_reg(REG_TTL, 32'd255);
        write_reg(REG_LINK_MTU, 32'd27);
        send_byte(8'h5F, 1'b1, 16'd14, 16'h1234);
        for (i = 0; i < 3; i++)
            send_byte(8'($urandom), 1'b0, 16'h0000, 16'h0000);
        drain_results();
        write_reg(REG_LOCAL_ADDR, 32'h0000_0000);
        write_reg(REG_REMOTE_ADDR, 32'hFFFF_FFFF);
        write_reg(REG_TTL, 32'd0);
        write_reg(REG_LINK_MTU, 32'd65535);
        for (i = 0; i < 10; i++)
            send_byte(8'($urandom), 1'b0, 16'h0000, 16'h0000);

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 25 : (phase == 1) ? 76 : 0;
            recv_idle = (phase == 0) ? 76 : (phase == 1) ? 25 : 0;
            for (blk = 0; blk < 4; blk++)
            begin
                drain_results();
                random_config();
                if (phase == 2 && blk == 0)
                begin
                    // long receiver hold-off while a long packet keeps coming
                    hold_req = 1'b1;
                    send_byte(8'($urandom), 1'b1, 16'd120, 16'($urandom));
                    for (i = 1; i < 120; i++)
                        send_byte(8'($urandom), 1'b0, 16'($urandom), 16'($urandom));
                end
                run_random(27);
            end
        end
        drain_results();

        if (fail_count == 0 && waiting == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
src/gref_pkg.sv
src/gref_fifo.sv
src/gref_front.sv
src/gref_back.sv
src/gre_ipv4_encap_fragmenter_unit.sv
src/gref_checker.sv
tb/sv/gref_frag_checker.sv
tb/sv/testbench.sv
